[rtl/sfs_pkg.sv]
package sfs_pkg;

	localparam int DEF_MAX_TERMS      = 64;
	localparam int DEF_COS_TABLE_BITS = 10;
	localparam int DEF_PHASE_BITS     = 16;

	localparam int PHASE_W  = 16;
	localparam int VALUE_W  = 17;
	localparam int TC_W     = 7;
	localparam int AMP_W    = 16;
	localparam int COS_W    = 17;
	localparam int GAIN_W   = 25;
	localparam int CA_W     = 32;
	localparam int PROD_W   = CA_W + GAIN_W + 1;
	localparam int ACC_W    = 62;
	localparam int RND_SHIFT = 39;
	localparam int RND_W    = ACC_W - RND_SHIFT;
	localparam int TERM_CMP_W = 9;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int unsigned GAIN_K = 21361415;

	localparam logic [TC_W-1:0]  TERM_COUNT_RST = 7'd1;
	localparam logic [AMP_W-1:0] AMPLITUDE_RST  = 16'd16384;

	localparam logic REG_TERM_COUNT = 1'b0;
	localparam logic REG_AMPLITUDE  = 1'b1;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 17'sd65535;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = -17'sd65536;

	localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(65535);
	localparam logic signed [RND_W-1:0] RND_MIN = -RND_W'(65536);

	localparam longint unsigned POLY0 = 64'd1324675879;
	localparam longint unsigned POLY1 = 64'd272375560;
	localparam longint unsigned POLY2 = 64'd22401992;
	localparam longint unsigned POLY3 = 64'd987050;
	localparam longint unsigned POLY4 = 64'd27061;

	typedef struct packed {
		logic issue;
		logic neg;
		logic clear;
	} mac_ctl_t;

	function automatic logic signed [COS_W-1:0] quarter_cos(longint unsigned k, int qbits);
		longint unsigned quarter;
		longint unsigned t;
		longint unsigned s;
		longint unsigned p;
		quarter = 64'd1 << qbits;
		if (k >= quarter) begin
			return '0;
		end
		t = k << (30 - qbits);
		s = (t * t) >> 30;
		p = POLY4;
		p = POLY3 - ((p * s) >> 30);
		p = POLY2 - ((p * s) >> 30);
		p = POLY1 - ((p * s) >> 30);
		p = POLY0 - ((p * s) >> 30);
		p = (64'd1 << 30) - ((p * s) >> 30);
		p = (p + (64'd1 << 14)) >> 15;
		return COS_W'(p);
	endfunction

	function automatic logic signed [COS_W-1:0] cos_entry(longint unsigned i, int cbits);
		int qbits;
		longint unsigned quarter;
		longint unsigned q;
		longint unsigned r;
		logic signed [COS_W-1:0] v;
		qbits = cbits - 2;
		quarter = 64'd1 << qbits;
		q = i >> qbits;
		r = i & (quarter - 64'd1);
		unique case (q)
			64'd0: v = quarter_cos(r, qbits);
			64'd1: v = -quarter_cos(quarter - r, qbits);
			64'd2: v = -quarter_cos(r, qbits);
			default: v = quarter_cos(quarter - r, qbits);
		endcase
		return v;
	endfunction

endpackage

[rtl/sfs_if.sv]
interface sfs_sample_if;
	logic                          valid;
	logic                          ready;
	logic [sfs_pkg::PHASE_W-1:0]   phase;

	modport source (output valid, output phase, input ready);
	modport sink (input valid, input phase, output ready);
endinterface

interface sfs_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [sfs_pkg::VALUE_W-1:0]  value;
	logic                                saturated;

	modport source (output valid, output value, output saturated, input ready);
	modport sink (input valid, input value, input saturated, output ready);
endinterface

[rtl/sfs_rom.sv]
module sfs_rom #(
	parameter int MAX_TERMS      = sfs_pkg::DEF_MAX_TERMS,
	parameter int COS_TABLE_BITS = sfs_pkg::DEF_COS_TABLE_BITS
) (
	input  logic                                   clk,
	input  logic [COS_TABLE_BITS-1:0]              cos_idx,
	input  logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] gain_idx,
	output logic signed [sfs_pkg::COS_W-1:0]       cos_s1,
	output logic [sfs_pkg::GAIN_W-1:0]             gain_s1
);

	localparam int COS_SIZE = 1 << COS_TABLE_BITS;

	logic signed [sfs_pkg::COS_W-1:0] cos_tab [COS_SIZE];
	logic [sfs_pkg::GAIN_W-1:0]       gain_tab [MAX_TERMS];

	for (genvar i = 0; i < COS_SIZE; i++) begin : g_cos
		assign cos_tab[i] = sfs_pkg::cos_entry(64'(i), COS_TABLE_BITS);
	end

	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_gain
		localparam int unsigned N  = 2 * g + 1;
		localparam int unsigned GV = (sfs_pkg::GAIN_K + N / 2) / N;
		assign gain_tab[g] = sfs_pkg::GAIN_W'(GV);
	end

	always_ff @(posedge clk) begin
		cos_s1  <= cos_tab[cos_idx];
		gain_s1 <= gain_tab[gain_idx];
	end

endmodule

[rtl/sfs_mac.sv]
module sfs_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sfs_pkg::mac_ctl_t                     ctl,
	input  logic [sfs_pkg::AMP_W-1:0]             amplitude,
	input  logic signed [sfs_pkg::COS_W-1:0]      cos_s1,
	input  logic [sfs_pkg::GAIN_W-1:0]            gain_s1,
	output logic signed [sfs_pkg::ACC_W-1:0]      acc,
	output logic                                  busy
);

	logic                                  v_s1, v_s2, v_s3;
	logic                                  neg_s1, neg_s2, neg_s3;
	logic signed [sfs_pkg::CA_W-1:0]       ca_s2;
	logic [sfs_pkg::GAIN_W-1:0]            gain_s2;
	logic signed [sfs_pkg::PROD_W-1:0]     prod_s3;
	logic signed [sfs_pkg::ACC_W-1:0]      acc_q;
	logic signed [2*sfs_pkg::COS_W-1:0]    ca_full;
	logic signed [sfs_pkg::PROD_W-1:0]     prod_full;

	assign ca_full   = cos_s1 * $signed({1'b0, amplitude});
	assign prod_full = ca_s2 * $signed({1'b0, gain_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= ctl.neg;
		neg_s2  <= neg_s1;
		neg_s3  <= neg_s2;
		ca_s2   <= ca_full[sfs_pkg::CA_W-1:0];
		gain_s2 <= gain_s1;
		prod_s3 <= prod_full;
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s3) begin
			if (neg_s3) begin
				acc_q <= acc_q - sfs_pkg::ACC_W'(prod_s3);
			end else begin
				acc_q <= acc_q + sfs_pkg::ACC_W'(prod_s3);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = v_s1 | v_s2 | v_s3;

endmodule

[rtl/square_wave_fourier_synth.sv]
// channel   direction  payload                       transfer when
// sample    in         phase[15:0]                   sample.valid && sample.ready
// result    out        value[16:0] s, saturated      result.valid && result.ready
// apb       in/out     term_count @0, amplitude @4   psel && penable && pwrite
//
// Each sample sums T harmonics, T the clamped term count, then its result is registered.
// The shared multiply-accumulate pipeline takes one harmonic per cycle; it sets the rate.
// sample.ready is high only while no sample is being summed.
// A finished result waits in the output register while the next sample is accepted.
// arst_n clears control state and the registers to term_count 1, amplitude 16384.
module square_wave_fourier_synth #(
	parameter int MAX_TERMS      = sfs_pkg::DEF_MAX_TERMS,
	parameter int COS_TABLE_BITS = sfs_pkg::DEF_COS_TABLE_BITS,
	parameter int PHASE_BITS     = sfs_pkg::DEF_PHASE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfs_pkg::APB_AW-1:0]    paddr,
	input  logic [sfs_pkg::APB_DW-1:0]    pwdata,
	output logic [sfs_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	sfs_sample_if.sink                    sample,
	sfs_result_if.source                  result
);

	localparam int KW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int TCW = $clog2(MAX_TERMS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                            state_q;
	logic [sfs_pkg::TC_W-1:0]              tc_q;
	logic [sfs_pkg::AMP_W-1:0]             amp_q;
	logic [PHASE_BITS-1:0]                 hp_q;
	logic [PHASE_BITS-1:0]                 step_q;
	logic [KW-1:0]                         k_q;
	logic [TCW-1:0]                        terms_q;
	logic                                  out_valid_q;
	logic signed [sfs_pkg::VALUE_W-1:0]    value_q;
	logic                                  sat_q;

	logic                                  cfg_wr;
	logic                                  in_xfer;
	logic                                  out_free;
	logic                                  last_term;
	logic [sfs_pkg::TERM_CMP_W-1:0]        tc_ext;
	logic [sfs_pkg::TERM_CMP_W-1:0]        tc_lim;
	logic [PHASE_BITS-1:0]                 ph_in;
	logic [COS_TABLE_BITS-1:0]             cos_idx;
	logic signed [sfs_pkg::COS_W-1:0]      cos_s1;
	logic [sfs_pkg::GAIN_W-1:0]            gain_s1;
	logic signed [sfs_pkg::ACC_W-1:0]      acc;
	logic                                  mac_busy;
	sfs_pkg::mac_ctl_t                     ctl;
	logic signed [sfs_pkg::ACC_W-1:0]      biased;
	logic signed [sfs_pkg::RND_W-1:0]      rnd;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[2])
			sfs_pkg::REG_TERM_COUNT: prdata = sfs_pkg::APB_DW'(tc_q);
			sfs_pkg::REG_AMPLITUDE:  prdata = sfs_pkg::APB_DW'(amp_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q  <= sfs_pkg::TERM_COUNT_RST;
			amp_q <= sfs_pkg::AMPLITUDE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sfs_pkg::REG_TERM_COUNT: tc_q  <= pwdata[sfs_pkg::TC_W-1:0];
				sfs_pkg::REG_AMPLITUDE:  amp_q <= pwdata[sfs_pkg::AMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign in_xfer      = sample.valid & sample.ready;
	assign ph_in        = PHASE_BITS'(sample.phase);

	always_comb begin
		tc_ext = sfs_pkg::TERM_CMP_W'(tc_q);
		priority if (tc_ext == '0) begin
			tc_lim = sfs_pkg::TERM_CMP_W'(1);
		end else if (tc_ext > sfs_pkg::TERM_CMP_W'(MAX_TERMS)) begin
			tc_lim = sfs_pkg::TERM_CMP_W'(MAX_TERMS);
		end else begin
			tc_lim = tc_ext;
		end
	end

	if (PHASE_BITS >= COS_TABLE_BITS) begin : g_idx_hi
		assign cos_idx = hp_q[PHASE_BITS-1 -: COS_TABLE_BITS];
	end else begin : g_idx_lo
		assign cos_idx = {hp_q, {(COS_TABLE_BITS - PHASE_BITS){1'b0}}};
	end

	assign last_term = ((TCW'(k_q) + TCW'(1)) == terms_q);

	assign ctl.issue = (state_q == ST_RUN);
	assign ctl.neg   = k_q[0];
	assign ctl.clear = in_xfer;

	sfs_rom #(
		.MAX_TERMS      (MAX_TERMS),
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_rom (
		.clk      (clk),
		.cos_idx  (cos_idx),
		.gain_idx (k_q),
		.cos_s1   (cos_s1),
		.gain_s1  (gain_s1)
	);

	sfs_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.amplitude (amp_q),
		.cos_s1    (cos_s1),
		.gain_s1   (gain_s1),
		.acc       (acc),
		.busy      (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_xfer) state_q <= ST_RUN;
				ST_RUN:   if (last_term) state_q <= ST_DRAIN;
				ST_DRAIN: if (!mac_busy) state_q <= ST_DONE;
				ST_DONE:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			hp_q    <= ph_in;
			step_q  <= {ph_in[PHASE_BITS-2:0], 1'b0};
			k_q     <= '0;
			terms_q <= TCW'(tc_lim);
		end else if (state_q == ST_RUN) begin
			hp_q <= hp_q + step_q;
			k_q  <= k_q + KW'(1);
		end
	end

	assign biased = acc + (sfs_pkg::ACC_W'(1) <<< (sfs_pkg::RND_SHIFT - 1));
	assign rnd    = sfs_pkg::RND_W'(biased >>> sfs_pkg::RND_SHIFT);

	assign out_free = ~out_valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			priority if (rnd > sfs_pkg::RND_MAX) begin
				value_q <= sfs_pkg::VALUE_MAX;
				sat_q   <= 1'b1;
			end else if (rnd < sfs_pkg::RND_MIN) begin
				value_q <= sfs_pkg::VALUE_MIN;
				sat_q   <= 1'b1;
			end else begin
				value_q <= sfs_pkg::VALUE_W'(rnd);
				sat_q   <= 1'b0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.value     = value_q;
	assign result.saturated = sat_q;

endmodule

[rtl/sfs_checker.sv]
module sfs_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [sfs_pkg::VALUE_W-1:0]   out_value,
	input logic                                 out_saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_saturated))
		else $error("result dropped or changed while stalled");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while summing");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after sample transfer");

	a_sat_clips: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated |->
			(out_value == sfs_pkg::VALUE_MAX || out_value == sfs_pkg::VALUE_MIN))
		else $error("saturated result not at a range limit");

endmodule

bind square_wave_fourier_synth sfs_checker u_sfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_value     (result.value),
	.out_saturated (result.saturated)
);
